>>> rtl/gpc_pkg.sv
package gpc_pkg;

    // Grid width used when the top level is instantiated without an override.
    localparam int GRID_WIDTH_DEF = 64;

    // Columns handled by one lane.
    localparam int LANE_W = 8;

    localparam int NUM_LANES_DEF = (GRID_WIDTH_DEF + LANE_W - 1) / LANE_W;

    // Column count register.
    localparam int              CFG_W              = 7;
    localparam logic [CFG_W-1:0] ACTIVE_COLUMNS_RST = CFG_W'(64);

    // What a lane reports to the merging stage about its edge columns.
    typedef struct packed {
        logic all_open;    // every column of the lane is open
        logic lo_reached;  // lowest column reached from seeds inside the lane
        logic hi_reached;  // highest column reached from seeds inside the lane
    } t_lane_flags;

endpackage

>>> rtl/gpc_row_if.sv
interface gpc_row_if #(
    parameter int GRID_WIDTH = gpc_pkg::GRID_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [GRID_WIDTH-1:0] row_open;
    logic                  last_row;

    modport source (output valid, output row_open, output last_row, input ready);
    modport sink   (input valid, input row_open, input last_row, output ready);
endinterface

>>> rtl/gpc_res_if.sv
interface gpc_res_if;
    logic valid;
    logic ready;
    logic percolates;

    modport source (output valid, output percolates, input ready);
    modport sink   (input valid, input percolates, output ready);
endinterface

>>> rtl/gpc_lane.sv
module gpc_lane (
    input  logic [gpc_pkg::LANE_W-1:0] i_open,
    input  logic [gpc_pkg::LANE_W-1:0] i_seed,
    output logic [gpc_pkg::LANE_W-1:0] o_fill,
    output logic [gpc_pkg::LANE_W-1:0] o_prefix,
    output logic [gpc_pkg::LANE_W-1:0] o_suffix,
    output gpc_pkg::t_lane_flags       o_flags
);
    import gpc_pkg::*;

    function automatic logic [LANE_W-1:0] rev(input logic [LANE_W-1:0] v);
        logic [LANE_W-1:0] r;
        for (int i = 0; i < LANE_W; i++) begin
            r[i] = v[LANE_W-1-i];
        end
        return r;
    endfunction

    logic [LANE_W-1:0] seed_open;
    logic [LANE_W-1:0] open_rev;
    logic [LANE_W-1:0] seed_rev;
    logic [LANE_W-1:0] fill_up;
    logic [LANE_W-1:0] fill_dn_rev;
    logic [LANE_W-1:0] suffix_rev;

    // Adding the seeds to the open mask sends a carry from the lowest seed of
    // each run to the top of that run; the bits it clears are the upward fill.
    // The same on the reversed vectors gives the downward fill.
    always_comb begin
        seed_open   = i_seed & i_open;
        open_rev    = rev(i_open);
        seed_rev    = rev(seed_open);
        fill_up     = (~(i_open + seed_open) & i_open) | seed_open;
        fill_dn_rev = (~(open_rev + seed_rev) & open_rev) | seed_rev;
        suffix_rev  = open_rev & ~(open_rev + LANE_W'(1));

        o_fill   = fill_up | rev(fill_dn_rev);
        o_prefix = i_open & ~(i_open + LANE_W'(1));
        o_suffix = rev(suffix_rev);

        o_flags.all_open   = &i_open;
        o_flags.lo_reached = o_fill[0];
        o_flags.hi_reached = o_fill[LANE_W-1];
    end

endmodule

>>> rtl/gpc_merge.sv
module gpc_merge #(
    parameter int NUM_LANES = gpc_pkg::NUM_LANES_DEF
) (
    input  logic [gpc_pkg::LANE_W-1:0]           i_fill   [NUM_LANES],
    input  logic [gpc_pkg::LANE_W-1:0]           i_prefix [NUM_LANES],
    input  logic [gpc_pkg::LANE_W-1:0]           i_suffix [NUM_LANES],
    input  gpc_pkg::t_lane_flags                 i_flags  [NUM_LANES],
    output logic [NUM_LANES*gpc_pkg::LANE_W-1:0] o_reached
);
    import gpc_pkg::*;

    logic [NUM_LANES-1:0] carry_up;  // reach entering lane k from lane k-1
    logic [NUM_LANES-1:0] carry_dn;  // reach entering lane k from lane k+1

    // A reach crosses a lane only when the whole lane is open, so the chain
    // is one AND-OR per lane in each direction.
    always_comb begin
        carry_up[0]           = 1'b0;
        carry_dn[NUM_LANES-1] = 1'b0;
        for (int k = 0; k < NUM_LANES - 1; k++) begin
            carry_up[k+1] = i_flags[k].hi_reached | (i_flags[k].all_open & carry_up[k]);
        end
        for (int k = NUM_LANES - 1; k > 0; k--) begin
            carry_dn[k-1] = i_flags[k].lo_reached | (i_flags[k].all_open & carry_dn[k]);
        end
        for (int k = 0; k < NUM_LANES; k++) begin
            o_reached[k*LANE_W +: LANE_W] = i_fill[k]
                                          | (i_prefix[k] & {LANE_W{carry_up[k]}})
                                          | (i_suffix[k] & {LANE_W{carry_dn[k]}});
        end
    end

endmodule

>>> rtl/grid_percolation_check.sv
// Top-to-bottom percolation check over a binary grid streamed one row per
// request, column i of a row open when bit i of row_open is set. A path may
// step down, left or right; row edges are walls. The block takes one row
// every clock cycle, and the whole sideways spread of a row (eight-column
// lanes joined by a carry chain across the lanes) settles in that cycle
// because the next row needs the reached mask this row leaves behind. The
// answer for a grid is offered in the cycle after its bottom row is taken;
// row requests are held off only while that answer waits to be taken.
// Columns at or above active_columns count as closed; the user writes the
// register only with no grid in flight and no answer pending (unchecked).
module grid_percolation_check #(
    parameter int GRID_WIDTH = gpc_pkg::GRID_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gpc_pkg::CFG_W-1:0] i_cfg_wdata,
    gpc_row_if.sink                   i_row,
    gpc_res_if.source                 o_res
);
    import gpc_pkg::*;

    localparam int NUM_LANES = (GRID_WIDTH + LANE_W - 1) / LANE_W;
    localparam int PAD_W     = NUM_LANES * LANE_W;

    logic [CFG_W-1:0]      r_active_columns;
    logic [GRID_WIDTH-1:0] r_reached_above;
    logic [GRID_WIDTH-1:0] n_reached_above;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_percolates;
    logic                  n_percolates;

    logic [GRID_WIDTH-1:0] col_mask;
    logic [GRID_WIDTH-1:0] open_masked;
    logic [PAD_W-1:0]      open_pad;
    logic [PAD_W-1:0]      seed_pad;
    logic [PAD_W-1:0]      reached_pad;
    logic [GRID_WIDTH-1:0] reached;
    logic                  row_accept;

    logic [LANE_W-1:0] lane_fill   [NUM_LANES];
    logic [LANE_W-1:0] lane_prefix [NUM_LANES];
    logic [LANE_W-1:0] lane_suffix [NUM_LANES];
    t_lane_flags       lane_flags  [NUM_LANES];

    // A count above the grid width simply opens every column.
    always_comb begin
        for (int i = 0; i < GRID_WIDTH; i++) begin
            col_mask[i] = (r_active_columns > CFG_W'(i));
        end
    end

    assign open_masked = GRID_WIDTH'(i_row.row_open) & col_mask;
    assign open_pad    = PAD_W'(open_masked);
    assign seed_pad    = PAD_W'(r_reached_above);

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        gpc_lane u_lane (
            .i_open   (open_pad[g*LANE_W +: LANE_W]),
            .i_seed   (seed_pad[g*LANE_W +: LANE_W]),
            .o_fill   (lane_fill[g]),
            .o_prefix (lane_prefix[g]),
            .o_suffix (lane_suffix[g]),
            .o_flags  (lane_flags[g])
        );
    end

    gpc_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .i_fill    (lane_fill),
        .i_prefix  (lane_prefix),
        .i_suffix  (lane_suffix),
        .i_flags   (lane_flags),
        .o_reached (reached_pad)
    );

    assign reached = reached_pad[GRID_WIDTH-1:0];

    assign i_row.ready      = !r_out_valid || o_res.ready;
    assign row_accept       = i_row.valid && i_row.ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.percolates = r_percolates;

    always_comb begin
        n_reached_above = r_reached_above;
        n_out_valid     = r_out_valid && !o_res.ready;
        n_percolates    = r_percolates;
        if (row_accept) begin
            if (i_row.last_row) begin
                // The bottom row closes the grid; the next row is a top row.
                n_reached_above = '1;
                n_out_valid     = 1'b1;
                n_percolates    = |reached;
            end else begin
                n_reached_above = reached;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_columns <= ACTIVE_COLUMNS_RST;
            r_reached_above  <= '1;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_columns <= i_cfg_wdata;
            end
            r_reached_above <= n_reached_above;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_percolates <= n_percolates;
    end

    a_last_row_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_accept && i_row.last_row |=> o_res.valid && (&r_reached_above))
        else $error("bottom row did not raise a result and restart the mask");

    a_reach_within_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_accept && !i_row.last_row |=>
            ((r_reached_above & ~$past(open_masked)) == '0))
        else $error("reached mask holds a closed cell");

    a_no_columns_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_accept && i_row.last_row && (r_active_columns == '0) |=> !o_res.percolates)
        else $error("grid with no active columns reported as percolating");

endmodule

>>> tb/grid_percolation_check_tb.sv
`timescale 1ns / 100ps

module grid_percolation_check_tb;

    import gpc_pkg::*;

    localparam int GRID_W      = GRID_WIDTH_DEF;
    localparam int TOTAL_ROWS  = 1350;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 4000;

    // Running copy of the reached mask and the column count, plus the answers
    // still owed by the block.
    class percolation_tracker;
        logic [CFG_W-1:0]  active_columns;
        logic [GRID_W-1:0] reached_above;
        logic              pending_answers[$];
        int                mismatches;

        function new();
            active_columns = ACTIVE_COLUMNS_RST;
            reached_above  = '1;
            mismatches     = 0;
        endfunction

        function void set_columns(logic [CFG_W-1:0] value);
            active_columns = value;
        endfunction

        function logic [GRID_W-1:0] column_mask();
            int n;
            n = active_columns;
            if (n > GRID_W) n = GRID_W;
            if (n >= GRID_W) return '1;
            return (GRID_W'(1) << n) - GRID_W'(1);
        endfunction

        // Grows the seeds sideways through open cells until nothing changes.
        function logic [GRID_W-1:0] spread_runs(logic [GRID_W-1:0] seed,
                                                logic [GRID_W-1:0] open);
            logic [GRID_W-1:0] r;
            logic [GRID_W-1:0] grown;
            r = seed & open;
            for (int k = 0; k < GRID_W; k++) begin
                grown = r | (((r << 1) | (r >> 1)) & open);
                if (grown == r) break;
                r = grown;
            end
            return r;
        endfunction

        function void take_row(logic [GRID_W-1:0] cells, logic bottom);
            logic [GRID_W-1:0] reached;
            reached = spread_runs(reached_above, cells & column_mask());
            if (bottom) begin
                pending_answers.push_back(reached != '0);
                reached_above = '1;
            end else begin
                reached_above = reached;
            end
        endfunction

        function void check_answer(logic got);
            logic want;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer %0b with no grid pending", got);
                return;
            end
            want = pending_answers.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("percolates mismatch: expected %0b, got %0b", want, got);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    gpc_row_if #(.GRID_WIDTH(GRID_W)) row_ch ();
    gpc_res_if                        res_ch ();

    grid_percolation_check #(.GRID_WIDTH(GRID_W)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_row       (row_ch),
        .o_res       (res_ch)
    );

    percolation_tracker tracker = new();

    int rows_sent;
    int idle_cycles;
    bit steady_flow;
    bit hold_request;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        row_ch.valid    <= 1'b0;
        row_ch.row_open <= '0;
        row_ch.last_row <= 1'b0;
    end

    // Monitor: answers are checked before a new bottom row is noted, so that
    // an answer and a bottom row in the same cycle keep their order.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready)
                tracker.check_answer(res_ch.percolates);
            if (row_ch.valid && row_ch.ready)
                tracker.take_row(row_ch.row_open, row_ch.last_row);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (row_ch.valid && row_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Answer side: random runs of ready, mostly short stalls and a few long
    // ones, and one long hold-off on request while rows keep coming.
    initial begin
        int run_left;
        bit level;
        run_left = 0;
        level    = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                run_left     = 0;
            end else begin
                if (run_left == 0) begin
                    if (steady_flow) begin
                        level    = 1'b1;
                        run_left = 1;
                    end else if ($urandom_range(0, 99) < 40) begin
                        level    = 1'b0;
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60)
                                                               : $urandom_range(1, 3);
                    end else begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 12);
                    end
                end
                res_ch.ready <= level;
                run_left--;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [GRID_W-1:0] random_cells(int density);
        logic [GRID_W-1:0] a;
        logic [GRID_W-1:0] b;
        logic [GRID_W-1:0] c;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        c = {$urandom(), $urandom()};
        case (density)
            0: return a & b;
            1: return a;
            2: return a | b;
            3: return a | b | c;
            default: return ~(GRID_W'(1) << $urandom_range(0, GRID_W - 1));
        endcase
    endfunction

    task automatic send_row(input logic [GRID_W-1:0] cells, input logic bottom);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_ch.valid    <= 1'b1;
        row_ch.row_open <= cells;
        row_ch.last_row <= bottom;
        do @(posedge clk); while (!row_ch.ready);
        rows_sent++;
    endtask

    // Stops offering rows and waits for every outstanding answer.
    task automatic drain_answers();
        row_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending_answers.size() != 0);
    endtask

    task automatic set_columns(input logic [CFG_W-1:0] value);
        drain_answers();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_columns(value);
    endtask

    task automatic send_random_grid();
        int rows;
        int r;
        int density;
        r = $urandom_range(0, 9);
        if (r < 7)      rows = $urandom_range(1, 8);
        else if (r < 9) rows = $urandom_range(9, 20);
        else            rows = 1;
        for (int i = 0; i < rows; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)     density = 0;
            else if (r == 1) density = 1;
            else if (r < 5) density = 2;
            else if (r < 8) density = 3;
            else            density = 4;
            send_row(random_cells(density), i == rows - 1);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] col_plan[9];
        int phase_end;

        rows_sent    = 0;
        steady_flow  = 1'b0;
        hold_request = 1'b0;
        col_plan = '{7'd1, 7'd64, 7'd2, 7'd63, 7'd127, 7'd65, 7'd8, 7'd0, 7'd33};
        col_plan[6] = CFG_W'($urandom_range(1, 64));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Single-row grids at the full width, both edge columns included.
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        send_row(64'h8000_0000_0000_0000, 1'b1);
        send_row(64'h1, 1'b1);
        // A path that dies in the middle row cannot come back.
        send_row(64'h1, 1'b0);
        send_row('0, 1'b0);
        send_row('1, 1'b1);
        // The row edges are walls: column 0 does not reach column 63.
        send_row(64'h1, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b1);
        // Sideways spread across the whole row, rightwards and leftwards.
        send_row(64'h1, 1'b0);
        send_row('1, 1'b0);
        send_row(64'h8000_0000_0000_0000, 1'b1);
        send_row(64'h8000_0000_0000_0000, 1'b0);
        send_row('1, 1'b0);
        send_row(64'h1, 1'b1);

        // Open cells in unused columns must be ignored.
        set_columns(7'd1);
        send_row(~64'h1, 1'b1);
        send_row(64'h1, 1'b1);
        set_columns(7'd0);
        send_row('1, 1'b1);
        set_columns(7'd127);
        send_row(64'h8000_0000_0000_0000, 1'b1);

        for (int p = 0; p < 9; p++) begin
            set_columns(col_plan[p]);
            steady_flow = (p == 5);
            if (p == 3) hold_request = 1'b1;
            phase_end = rows_sent + (TOTAL_ROWS - rows_sent) / (9 - p);
            while (rows_sent < phase_end) begin
                send_random_grid();
                if ($urandom_range(0, 19) == 0) drain_answers();
            end
        end
        steady_flow = 1'b0;

        drain_answers();
        repeat (4) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
